FILE: src/aigs_pkg.sv
// Shared types, constants and helper functions for the alpha invert gradient shader.
`default_nettype none

package aigs_pkg;

  // Field and register widths
  localparam int PIX_W           = 32;
  localparam int AREA_W          = 21;
  localparam int FMT_W           = 2;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 21;
  localparam int CH_W            = 5;
  localparam int Q_W             = 6;
  localparam int OFFSET_BITS_DEF = 20;

  // Alpha flip masks: full alpha byte and high nibble of the 16-bit word
  localparam logic [PIX_W-1:0]  ALPHA8_FLIP = 32'hFF00_0000;
  localparam logic [PIX_W-1:0]  ALPHA4_FLIP = 32'h0000_F000;
  localparam logic [AREA_W-1:0] AREA_RESET  = 21'd131072;

  typedef enum logic [FMT_W-1:0] {
    FMT_ARGB8888 = 2'd0,
    FMT_ARGB1555 = 2'd1,
    FMT_ARGB4444 = 2'd2,
    FMT_UNSUP    = 2'd3
  } fmt_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIXEL_FORMAT = 2'd0,
    REG_AREA_BYTES   = 2'd1,
    REG_SHADE_MODE   = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    DIV_BY_2 = 2'd0,
    DIV_BY_3 = 2'd1,
    DIV_BY_4 = 2'd2
  } div_e;

  // Sideband that rides along the divider chain with each pixel
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             unsup;
    logic             shade;
    logic             red_ge_blue;
    div_e             div;
  } side_t;

  // Scale a gradient quotient down by the final small divisor
  function automatic logic [Q_W-1:0] scale_drop(input logic [Q_W-1:0] q, input div_e d);
    logic [Q_W+5:0] prod;
    logic [Q_W-1:0] res;
    // q/3 as q*43 >> 7, exact for every 6-bit q
    prod = (Q_W+6)'(q) * (Q_W+6)'(43);
    unique case (d)
      DIV_BY_2: res = q >> 1;
      DIV_BY_3: res = Q_W'(prod[Q_W+5:7]);
      DIV_BY_4: res = q >> 2;
      default:  res = '0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: src/aigs_front.sv
// Entry stage: decode the pixel format, bounds checks and gradient numerators.
`default_nettype none

module aigs_front #(
  parameter int OFFSET_BITS = 20,
  parameter int DV_W        = 27
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         en_i,
  input  wire                         valid_i,
  input  wire  [aigs_pkg::PIX_W-1:0]  pixel_i,
  input  wire  [OFFSET_BITS-1:0]      offset_i,
  input  wire  aigs_pkg::fmt_e        fmt_i,
  input  wire  [aigs_pkg::AREA_W-1:0] area_i,
  input  wire                         mode_i,
  output logic                        valid_o,
  output logic [DV_W-1:0]             rem0_o,
  output logic [DV_W-1:0]             rem1_o,
  output aigs_pkg::side_t             side_o
);
  import aigs_pkg::*;

  localparam int CMP_W = ((OFFSET_BITS > AREA_W) ? OFFSET_BITS : AREA_W) + 1;

  logic [CMP_W-1:0] off_w, area_w;
  logic             in8, in4, in1;
  logic [CH_W-1:0]  red, green, blue, c0;
  logic             rb, steep;
  logic [Q_W-1:0]   m0, m1;
  logic [DV_W-1:0]  n0, n1;
  side_t            side_d, side_q;
  logic             valid_q;
  logic [DV_W-1:0]  rem0_q, rem1_q;

  // Bounds checks against the region size
  assign off_w  = CMP_W'(offset_i);
  assign area_w = CMP_W'(area_i);
  assign in8    = (off_w + CMP_W'(3)) < area_w;
  assign in4    = (off_w + CMP_W'(1)) < area_w;
  assign in1    = off_w < area_w;

  // Pick the two channels to darken and their numerators c*mul*offset
  assign red   = pixel_i[14:10];
  assign green = pixel_i[9:5];
  assign blue  = pixel_i[4:0];
  assign rb    = red >= blue;
  assign c0    = rb ? red : blue;
  assign steep = !mode_i && rb;
  assign m0    = steep ? {c0, 1'b0} : {1'b0, c0};
  assign m1    = steep ? {green, 1'b0} : {1'b0, green};
  assign n0    = DV_W'(m0) * DV_W'(offset_i);
  assign n1    = DV_W'(m1) * DV_W'(offset_i);

  // Resolve everything that needs no division right here
  always_comb begin
    side_d             = '0;
    side_d.pixel       = pixel_i;
    side_d.red_ge_blue = rb;
    if (mode_i) begin
      side_d.div = DIV_BY_4;
    end else if (rb) begin
      side_d.div = DIV_BY_3;
    end else begin
      side_d.div = DIV_BY_2;
    end
    unique case (fmt_i)
      FMT_ARGB8888: begin
        if (in8) side_d.pixel = pixel_i ^ ALPHA8_FLIP;
      end
      FMT_ARGB4444: begin
        if (in4) side_d.pixel = pixel_i ^ ALPHA4_FLIP;
      end
      FMT_ARGB1555: begin
        if (in1) begin
          if (pixel_i[15]) begin
            // New alpha is zero: clear color
            side_d.pixel = {pixel_i[31:16], 16'h0000};
          end else begin
            side_d.shade = 1'b1;
          end
        end
      end
      default: begin
        side_d.unsup = 1'b1;
      end
    endcase
  end

  // Stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      side_q <= side_d;
      rem0_q <= n0;
      rem1_q <= n1;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign rem0_o  = rem0_q;
  assign rem1_o  = rem1_q;

endmodule

`default_nettype wire

FILE: src/aigs_cell.sv
// Divider cell: one restoring quotient bit for both channels per stage.
`default_nettype none

module aigs_cell #(
  parameter int DV_W  = 27,
  parameter int SHIFT = 0
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         en_i,
  input  wire                         valid_i,
  input  wire  [aigs_pkg::AREA_W-1:0] area_i,
  input  wire  [DV_W-1:0]             rem0_i,
  input  wire  [DV_W-1:0]             rem1_i,
  input  wire  [aigs_pkg::Q_W-1:0]    q0_i,
  input  wire  [aigs_pkg::Q_W-1:0]    q1_i,
  input  wire  aigs_pkg::side_t       side_i,
  output logic                        valid_o,
  output logic [DV_W-1:0]             rem0_o,
  output logic [DV_W-1:0]             rem1_o,
  output logic [aigs_pkg::Q_W-1:0]    q0_o,
  output logic [aigs_pkg::Q_W-1:0]    q1_o,
  output aigs_pkg::side_t             side_o
);
  import aigs_pkg::*;

  logic [DV_W-1:0] trial;
  logic            hit0, hit1;
  logic            valid_q;
  logic [DV_W-1:0] rem0_q, rem1_q;
  logic [Q_W-1:0]  q0_q, q1_q;
  side_t           side_q;

  // Compare against the region size weighted by this bit
  assign trial = DV_W'(area_i) << SHIFT;
  assign hit0  = rem0_i >= trial;
  assign hit1  = rem1_i >= trial;

  // Stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Subtract where it fits and record the quotient bit
  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      rem0_q <= hit0 ? rem0_i - trial : rem0_i;
      rem1_q <= hit1 ? rem1_i - trial : rem1_i;
      q0_q   <= q0_i | (Q_W'(hit0) << SHIFT);
      q1_q   <= q1_i | (Q_W'(hit1) << SHIFT);
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem0_o  = rem0_q;
  assign rem1_o  = rem1_q;
  assign q0_o    = q0_q;
  assign q1_o    = q1_q;
  assign side_o  = side_q;

endmodule

`default_nettype wire

FILE: src/aigs_back.sv
// Output stage: apply the gradient drop, assemble the pixel and hold the result.
`default_nettype none

module aigs_back (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        en_i,
  input  wire                        valid_i,
  input  wire  [aigs_pkg::Q_W-1:0]   q0_i,
  input  wire  [aigs_pkg::Q_W-1:0]   q1_i,
  input  wire  aigs_pkg::side_t      side_i,
  output logic                       valid_o,
  output logic [aigs_pkg::PIX_W-1:0] pixel_o,
  output logic                       unsup_o
);
  import aigs_pkg::*;

  logic [CH_W-1:0]  red, green, blue, c0, n0, n1;
  logic [Q_W-1:0]   d0, d1;
  logic [PIX_W-1:0] pixel_d;
  logic             valid_q;
  logic [PIX_W-1:0] pixel_q;
  logic             unsup_q;

  // Darken the two selected channels
  assign red   = side_i.pixel[14:10];
  assign green = side_i.pixel[9:5];
  assign blue  = side_i.pixel[4:0];
  assign c0    = side_i.red_ge_blue ? red : blue;
  assign d0    = scale_drop(q0_i, side_i.div);
  assign d1    = scale_drop(q1_i, side_i.div);
  assign n0    = c0 - d0[CH_W-1:0];
  assign n1    = green - d1[CH_W-1:0];

  // Assemble the shaded pixel with alpha set
  always_comb begin
    pixel_d = side_i.pixel;
    if (side_i.shade) begin
      if (side_i.red_ge_blue) begin
        pixel_d = {side_i.pixel[31:16], 1'b1, n0, n1, blue};
      end else begin
        pixel_d = {side_i.pixel[31:16], 1'b1, red, n1, n0};
      end
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      pixel_q <= pixel_d;
      unsup_q <= side_i.unsup;
    end
  end

  assign valid_o = valid_q;
  assign pixel_o = pixel_q;
  assign unsup_o = unsup_q;

endmodule

`default_nettype wire

FILE: src/alpha_invert_gradient_shader_core.sv
// Top level of the alpha invert gradient shader: config registers and the cell chain.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries a pixel word and its byte offset
//   in the region; output channel (out_valid_o/out_ready_i) returns the processed
//   pixel and the unsupported flag, one result per input, in order.
//   Config channel (cfg_valid_i/cfg_ready_o) writes pixel_format (index 0),
//   area_bytes (index 1) and shade_mode (index 2); it is always ready and should
//   only be written while no pixel is in flight.
//   Pipeline: a result passes through one entry stage, six divider cells (one
//   quotient bit of offset*c*mul/area each) and one output register.
//   Throughput: one pixel per clock; every stage is a register, so a new pixel
//   enters in each cycle in which the chain moves.
//   Stall: when the receiver holds out_ready_i low, the output register keeps
//   its transfer and earlier stages keep filling empty slots behind it; input
//   ready drops only once every stage, the entry stage included, is full.
//   Reset: all stage valids clear; pixel_format resets to unsupported,
//   area_bytes to 131072 and shade_mode to 0.
`default_nettype none

module alpha_invert_gradient_shader_core #(
  parameter int OFFSET_BITS = aigs_pkg::OFFSET_BITS_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  wire  [aigs_pkg::PIX_W-1:0]      pixel_in_i,
  input  wire  [OFFSET_BITS-1:0]          byte_offset_i,
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output logic [aigs_pkg::PIX_W-1:0]      pixel_out_o,
  output logic                            unsupported_o,
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire  [aigs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [aigs_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import aigs_pkg::*;

  localparam int N_W    = Q_W + OFFSET_BITS;
  localparam int SH_W   = AREA_W + Q_W;
  localparam int DV_W   = (N_W > SH_W) ? N_W : SH_W;
  localparam int LAST   = Q_W + 1;

  fmt_e              pixel_format_q;
  logic [AREA_W-1:0] area_q;
  logic              shade_mode_q;

  logic [LAST:0]     vld;
  logic [LAST:0]     en;
  logic [DV_W-1:0]   rem0 [0:Q_W-1];
  logic [DV_W-1:0]   rem1 [0:Q_W-1];
  logic [Q_W-1:0]    q0   [0:Q_W];
  logic [Q_W-1:0]    q1   [0:Q_W];
  side_t             side [0:Q_W];

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_format_q <= FMT_UNSUP;
      area_q         <= AREA_RESET;
      shade_mode_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_PIXEL_FORMAT: pixel_format_q <= fmt_e'(cfg_data_i[FMT_W-1:0]);
        REG_AREA_BYTES:   area_q         <= cfg_data_i[AREA_W-1:0];
        REG_SHADE_MODE:   shade_mode_q   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Advance each stage when it is empty or the stage after it moves
  always_comb begin
    en[LAST] = !vld[LAST] || out_ready_i;
    for (int s = LAST - 1; s >= 0; s--) begin
      en[s] = !vld[s] || en[s+1];
    end
  end

  assign in_ready_o = en[0];

  aigs_front #(
    .OFFSET_BITS (OFFSET_BITS),
    .DV_W        (DV_W)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en[0]),
    .valid_i  (in_valid_i),
    .pixel_i  (pixel_in_i),
    .offset_i (byte_offset_i),
    .fmt_i    (pixel_format_q),
    .area_i   (area_q),
    .mode_i   (shade_mode_q),
    .valid_o  (vld[0]),
    .rem0_o   (rem0[0]),
    .rem1_o   (rem1[0]),
    .side_o   (side[0])
  );

  assign q0[0] = '0;
  assign q1[0] = '0;

  // Divider chain, most significant quotient bit first
  for (genvar j = 0; j < Q_W; j++) begin : g_cell
    if (j < Q_W - 1) begin : g_mid
      aigs_cell #(
        .DV_W  (DV_W),
        .SHIFT (Q_W - 1 - j)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en[j+1]),
        .valid_i (vld[j]),
        .area_i  (area_q),
        .rem0_i  (rem0[j]),
        .rem1_i  (rem1[j]),
        .q0_i    (q0[j]),
        .q1_i    (q1[j]),
        .side_i  (side[j]),
        .valid_o (vld[j+1]),
        .rem0_o  (rem0[j+1]),
        .rem1_o  (rem1[j+1]),
        .q0_o    (q0[j+1]),
        .q1_o    (q1[j+1]),
        .side_o  (side[j+1])
      );
    end else begin : g_end
      aigs_cell #(
        .DV_W  (DV_W),
        .SHIFT (Q_W - 1 - j)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en[j+1]),
        .valid_i (vld[j]),
        .area_i  (area_q),
        .rem0_i  (rem0[j]),
        .rem1_i  (rem1[j]),
        .q0_i    (q0[j]),
        .q1_i    (q1[j]),
        .side_i  (side[j]),
        .valid_o (vld[j+1]),
        .rem0_o  (),
        .rem1_o  (),
        .q0_o    (q0[j+1]),
        .q1_o    (q1[j+1]),
        .side_o  (side[j+1])
      );
    end
  end

  aigs_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[LAST]),
    .valid_i (vld[Q_W]),
    .q0_i    (q0[Q_W]),
    .q1_i    (q1[Q_W]),
    .side_i  (side[Q_W]),
    .valid_o (vld[LAST]),
    .pixel_o (pixel_out_o),
    .unsup_o (unsupported_o)
  );

  assign out_valid_o = vld[LAST];

endmodule

`default_nettype wire
